/* rtl/core/tpmig_pkg.sv */
// Shared types, constants and helpers for the triangular patch index generator.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package tpmig_pkg;

	localparam int MAX_SUBDIVISIONS = 64;
	localparam int MAX_PATCHES      = 65536;

	localparam int S_W     = 7;   // subdivisions register
	localparam int PC_W    = 17;  // patch_count register
	localparam int PATCH_W = 16;
	localparam int POS_W   = 6;   // col / row
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 28;
	localparam int CB_W    = 12;  // vertex offset inside one patch
	localparam int CFG_W   = 17;

	// pass selector codes
	localparam logic [MODE_W-1:0] MODE_PREV_COL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALONG    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DIAG     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TRI      = 2'd3;

	// register indexes
	localparam logic REG_SUBDIV      = 1'b0;
	localparam logic REG_PATCH_COUNT = 1'b1;

	typedef struct packed {
		logic [PATCH_W-1:0] patch;
		logic [POS_W-1:0]   col;
		logic [POS_W-1:0]   row;
		logic [MODE_W-1:0]  mode;
	} cell_t;

	typedef struct packed {
		logic [IDX_W-1:0] index_a;
		logic [IDX_W-1:0] index_b;
		logic [IDX_W-1:0] index_c;
		logic             is_triangle;
		logic             last;
	} prim_t;

	// after decode: column bases and routing
	typedef struct packed {
		logic [PATCH_W-1:0] patch;
		logic [CB_W-1:0]    per_patch;
		logic [POS_W-1:0]   row;
		logic [MODE_W-1:0]  mode;
		logic               up_first;
		logic               two;
		logic [CB_W-1:0]    cb_m;   // column ix-1
		logic [CB_W-1:0]    cb_0;   // column ix
		logic [CB_W-1:0]    cb_p;   // column ix+1
	} dec_t;

	// after patch base multiply: base plus in-patch offsets
	typedef struct packed {
		logic [IDX_W-1:0] base;
		logic [CB_W-1:0]  off_a;
		logic [CB_W-1:0]  off_b1;
		logic [CB_W-1:0]  off_c1;
		logic [CB_W-1:0]  off_b2;
		logic [CB_W-1:0]  off_c2;
		logic             is_tri;
		logic             two;
	} ofs_t;

	// first vertex of column ix: ix*(2s+1-ix)/2
	function automatic logic [CB_W-1:0] col_base(input logic [S_W-1:0] s,
		input logic [S_W-1:0] ix);
		logic [S_W:0]     span;
		logic [2*S_W:0]   prod;
		span = {s, 1'b0} + (S_W+1)'(1) - {1'b0, ix};
		prod = (2*S_W+1)'(ix) * (2*S_W+1)'(span);
		return prod[CB_W:1];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/tpmig_decode.sv */
// Stage 1: range checks, result count and column bases for one cell.
// Depends on tpmig_pkg.
`default_nettype none

module tpmig_decode (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [tpmig_pkg::S_W-1:0] s_eff,
	input  wire logic [tpmig_pkg::PC_W-1:0] pc_eff,
	input  wire logic                      up_valid,
	output logic                           up_ready,
	input  wire tpmig_pkg::cell_t          up_data,
	output logic                           dn_valid,
	input  wire logic                      dn_ready,
	output tpmig_pkg::dec_t                dn_data
);
	import tpmig_pkg::*;

	logic           v_s1;
	dec_t           d_s1;
	dec_t           d_next;
	logic [S_W-1:0] ix, iy, room, ix_inc, iy_inc;
	logic [S_W-2:0] half;
	logic           in_cell, next_ok, has_left, up, down, keep;

	always_comb begin
		ix      = {1'b0, up_data.col};
		iy      = {1'b0, up_data.row};
		ix_inc  = ix + S_W'(1);
		iy_inc  = iy + S_W'(1);
		room    = s_eff - ix;
		in_cell = ({1'b0, up_data.patch} < pc_eff) && (ix < s_eff) && (iy < room);
		next_ok = iy_inc < room;
		has_left = up_data.col != '0;
		up      = (ix_inc < s_eff) && next_ok;
		down    = has_left && (up_data.row != '0);
		case (up_data.mode)
			MODE_PREV_COL: keep = has_left;
			MODE_ALONG:    keep = next_ok;
			MODE_DIAG:     keep = has_left;
			MODE_TRI:      keep = up || down;
			default:       keep = 1'b0;
		endcase
		keep = keep && in_cell;

		half               = (S_W-1)'((s_eff + S_W'(1)) >> 1);
		d_next.patch       = up_data.patch;
		d_next.per_patch   = CB_W'(s_eff) * CB_W'(half);
		d_next.row         = up_data.row;
		d_next.mode        = up_data.mode;
		d_next.up_first    = up;
		d_next.two         = (up_data.mode == MODE_TRI) && up && down;
		d_next.cb_m        = col_base(s_eff, ix - S_W'(1));
		d_next.cb_0        = col_base(s_eff, ix);
		d_next.cb_p        = col_base(s_eff, ix_inc);
	end

	assign up_ready = !v_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= up_valid && keep;  // cells with no result drop here
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			d_s1 <= d_next;
		end
	end

	assign dn_valid = v_s1;
	assign dn_data  = d_s1;

endmodule

`default_nettype wire

/* rtl/core/tpmig_offset.sv */
// Stage 2: patch base multiply and neighbour offsets within the patch.
// Depends on tpmig_pkg.
`default_nettype none

module tpmig_offset (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            up_valid,
	output logic                 up_ready,
	input  wire tpmig_pkg::dec_t up_data,
	output logic                 dn_valid,
	input  wire logic            dn_ready,
	output tpmig_pkg::ofs_t      dn_data
);
	import tpmig_pkg::*;

	logic            v_s2;
	ofs_t            o_s2;
	ofs_t            o_next;
	logic [CB_W-1:0] row, row_inc, row_dec;

	always_comb begin
		row     = CB_W'(up_data.row);
		row_inc = row + CB_W'(1);
		row_dec = row - CB_W'(1);

		o_next.base   = IDX_W'(up_data.patch) * IDX_W'(up_data.per_patch);
		o_next.off_a  = up_data.cb_0 + row;
		o_next.off_c1 = '0;
		// second beat of a pair is always the downward triangle
		o_next.off_b2 = up_data.cb_0 + row_dec;
		o_next.off_c2 = up_data.cb_m + row;
		o_next.is_tri = up_data.mode == MODE_TRI;
		o_next.two    = up_data.two;
		case (up_data.mode)
			MODE_PREV_COL: o_next.off_b1 = up_data.cb_m + row;
			MODE_ALONG:    o_next.off_b1 = up_data.cb_0 + row_inc;
			MODE_DIAG:     o_next.off_b1 = up_data.cb_m + row_inc;
			MODE_TRI: begin
				if (up_data.up_first) begin
					o_next.off_b1 = up_data.cb_0 + row_inc;
					o_next.off_c1 = up_data.cb_p + row;
				end else begin
					o_next.off_b1 = up_data.cb_0 + row_dec;
					o_next.off_c1 = up_data.cb_m + row;
				end
			end
			default:       o_next.off_b1 = '0;
		endcase
	end

	assign up_ready = !v_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (up_ready) begin
			v_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			o_s2 <= o_next;
		end
	end

	assign dn_valid = v_s2;
	assign dn_data  = o_s2;

endmodule

`default_nettype wire

/* rtl/core/tpmig_emit.sv */
// Stage 3: final index adds and the output register, one beat per result.
// Depends on tpmig_pkg.
`default_nettype none

module tpmig_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            up_valid,
	output logic                 up_ready,
	input  wire tpmig_pkg::ofs_t up_data,
	output logic                 prim_valid,
	input  wire logic            prim_ready,
	output tpmig_pkg::prim_t     prim
);
	import tpmig_pkg::*;

	logic             v_s3;
	logic             phase_q;
	logic [IDX_W-1:0] a_s3, b1_s3, c1_s3, b2_s3, c2_s3;
	logic             tri_s3, two_s3;
	logic             done;

	// a pair holds the stage for two beats
	assign done     = v_s3 && prim_ready && (!two_s3 || phase_q);
	assign up_ready = !v_s3 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (up_ready) begin
				v_s3    <= up_valid;
				phase_q <= 1'b0;
			end else if (prim_ready) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			a_s3   <= up_data.base + IDX_W'(up_data.off_a);
			b1_s3  <= up_data.base + IDX_W'(up_data.off_b1);
			c1_s3  <= up_data.is_tri ? up_data.base + IDX_W'(up_data.off_c1) : '0;
			b2_s3  <= up_data.base + IDX_W'(up_data.off_b2);
			c2_s3  <= up_data.base + IDX_W'(up_data.off_c2);
			tri_s3 <= up_data.is_tri;
			two_s3 <= up_data.two;
		end
	end

	assign prim_valid       = v_s3;
	assign prim.index_a     = a_s3;
	assign prim.index_b     = phase_q ? b2_s3 : b1_s3;
	assign prim.index_c     = phase_q ? c2_s3 : c1_s3;
	assign prim.is_triangle = tri_s3;
	assign prim.last        = !two_s3 || phase_q;

endmodule

`default_nettype wire

/* rtl/core/tri_patch_mesh_index_generator.sv */
// Path: cell beat -> decode, offset, emit registers -> first result beat.
// Throughput: one cell per cycle while prim_ready stays high; a cell giving two
// triangles takes two output beats, so the output port's one beat per cycle sets
// the rate for such cells. Cells with no result are dropped in the decode stage.
// Reset (arst_n low, async) empties the pipe and sets subdivisions 17, patch count 1.
`default_nettype none

module tri_patch_mesh_index_generator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_addr,
	input  wire logic [tpmig_pkg::CFG_W-1:0] cfg_wdata,
	input  wire logic                        cell_valid,
	output logic                             cell_ready,
	input  wire tpmig_pkg::cell_t            patch_cell,
	output logic                             prim_valid,
	input  wire logic                        prim_ready,
	output tpmig_pkg::prim_t                 prim
);
	import tpmig_pkg::*;

	logic [S_W-1:0]  subdiv_q;
	logic [PC_W-1:0] patch_count_q;
	logic [S_W-1:0]  s_eff;
	logic [PC_W-1:0] pc_eff;

	logic            dec_valid, dec_ready, ofs_valid, ofs_ready;
	dec_t            dec_data;
	ofs_t            ofs_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subdiv_q      <= S_W'(17);
			patch_count_q <= PC_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SUBDIV:      subdiv_q      <= cfg_wdata[S_W-1:0];
				REG_PATCH_COUNT: patch_count_q <= cfg_wdata[PC_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_eff  = (subdiv_q > S_W'(MAX_SUBDIVISIONS)) ? S_W'(MAX_SUBDIVISIONS) : subdiv_q;
	assign pc_eff = (patch_count_q > PC_W'(MAX_PATCHES)) ? PC_W'(MAX_PATCHES)
		: patch_count_q;

	tpmig_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_eff    (s_eff),
		.pc_eff   (pc_eff),
		.up_valid (cell_valid),
		.up_ready (cell_ready),
		.up_data  (patch_cell),
		.dn_valid (dec_valid),
		.dn_ready (dec_ready),
		.dn_data  (dec_data)
	);

	tpmig_offset u_offset (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dec_valid),
		.up_ready (dec_ready),
		.up_data  (dec_data),
		.dn_valid (ofs_valid),
		.dn_ready (ofs_ready),
		.dn_data  (ofs_data)
	);

	tpmig_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (ofs_valid),
		.up_ready   (ofs_ready),
		.up_data    (ofs_data),
		.prim_valid (prim_valid),
		.prim_ready (prim_ready),
		.prim       (prim)
	);

	// only the upward triangle of a pair may be non-last
	a_pair_first_tri: assert property (@(posedge clk) disable iff (!arst_n)
		prim_valid && !prim.last |-> prim.is_triangle)
		else $error("non-last beat is not a triangle");

	a_line_shape: assert property (@(posedge clk) disable iff (!arst_n)
		prim_valid && !prim.is_triangle |-> prim.index_c == '0 && prim.last)
		else $error("line beat with third index or without last");

	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		prim_valid && prim_ready && !prim.last |=>
			prim_valid && prim.is_triangle && prim.last)
		else $error("second triangle of a pair missing");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking bench for tri_patch_mesh_index_generator: random cells against an
// in-bench index predictor, with random idling on both sides and config phases.
// Depends on rtl/core/tpmig_pkg.sv and the top-level RTL.
`timescale 1ns / 100ps

module tb_top;
	import tpmig_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_addr;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               cell_valid;
	logic               cell_ready;
	cell_t              patch_cell;
	logic               prim_valid;
	logic               prim_ready;
	prim_t              prim;

	prim_t              pending_prims[$];
	int                 errors;
	bit                 in_idle;
	bit                 out_idle;
	int                 hold_cycles;
	logic [S_W-1:0]     model_subdiv;
	logic [PC_W-1:0]    model_patches;

	tri_patch_mesh_index_generator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.patch_cell (patch_cell),
		.prim_valid (prim_valid),
		.prim_ready (prim_ready),
		.prim       (prim)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int eff_subdiv();
		return (model_subdiv > MAX_SUBDIVISIONS) ? MAX_SUBDIVISIONS : int'(model_subdiv);
	endfunction

	function automatic int eff_patches();
		return (model_patches > MAX_PATCHES) ? MAX_PATCHES : int'(model_patches);
	endfunction

	function automatic logic [IDX_W-1:0] vertex_index(int s, int p, int ix, int iy);
		longint unsigned v;
		v = longint'(p) * longint'(s * ((s + 1) / 2)) + longint'((ix * (2 * s + 1 - ix)) / 2)
			+ longint'(iy);
		return v[IDX_W-1:0];
	endfunction

	function automatic void push_prim(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
		logic [IDX_W-1:0] c, logic tri_flag, logic last_flag);
		prim_t r;
		r.index_a     = a;
		r.index_b     = b;
		r.index_c     = c;
		r.is_triangle = tri_flag;
		r.last        = last_flag;
		pending_prims.push_back(r);
	endfunction

	// expected output beats for one accepted cell
	function automatic void predict_prims(cell_t c);
		int s, pc, p, ix, iy;
		bit up, down;
		logic [IDX_W-1:0] self_idx;
		s  = eff_subdiv();
		pc = eff_patches();
		p  = int'(c.patch);
		ix = int'(c.col);
		iy = int'(c.row);
		if (p >= pc || ix >= s || iy >= s - ix)
			return;
		self_idx = vertex_index(s, p, ix, iy);
		case (c.mode)
			MODE_PREV_COL: begin
				if (ix != 0)
					push_prim(self_idx, vertex_index(s, p, ix - 1, iy), '0, 1'b0, 1'b1);
			end
			MODE_ALONG: begin
				if (iy + 1 < s - ix)
					push_prim(self_idx, vertex_index(s, p, ix, iy + 1), '0, 1'b0, 1'b1);
			end
			MODE_DIAG: begin
				if (ix != 0)
					push_prim(self_idx, vertex_index(s, p, ix - 1, iy + 1), '0, 1'b0, 1'b1);
			end
			default: begin
				up   = (ix + 1 < s) && (iy + 1 < s - ix);
				down = (ix > 0) && (iy > 0);
				if (up)
					push_prim(self_idx, vertex_index(s, p, ix, iy + 1),
						vertex_index(s, p, ix + 1, iy), 1'b1, !down);
				if (down)
					push_prim(self_idx, vertex_index(s, p, ix, iy - 1),
						vertex_index(s, p, ix - 1, iy), 1'b1, 1'b1);
			end
		endcase
	endfunction

	task automatic report_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_prim(prim_t got);
		prim_t want;
		if (pending_prims.size() == 0) begin
			$display("%0t: unexpected beat, expected none got %h", $time, got);
			errors++;
			return;
		end
		want = pending_prims.pop_front();
		report_field("index_a", want.index_a, got.index_a);
		report_field("index_b", want.index_b, got.index_b);
		report_field("index_c", want.index_c, got.index_c);
		report_field("is_triangle", IDX_W'(want.is_triangle), IDX_W'(got.is_triangle));
		report_field("last", IDX_W'(want.last), IDX_W'(got.last));
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				prim_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				int stall;
				stall = out_idle ? $urandom_range(0, 13) : 0;
				if (stall > 0) begin
					prim_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			prim_ready <= 1'b1;
			do @(negedge clk); while (prim_valid !== 1'b1);
			check_prim(prim);
			@(posedge clk);
		end
	end

	// called at a rising edge; returns at the edge that takes the beat, valid still high
	task automatic send_cell(cell_t c);
		int gap;
		gap = in_idle ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		patch_cell <= c;
		cell_valid <= 1'b1;
		do @(negedge clk); while (cell_ready !== 1'b1);
		predict_prims(c);
		@(posedge clk);
	endtask

	task automatic wait_idle();
		cell_valid <= 1'b0;
		while (pending_prims.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic addr, logic [CFG_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_SUBDIV)
			model_subdiv = value[S_W-1:0];
		else
			model_patches = value[PC_W-1:0];
	endtask

	function automatic cell_t random_cell();
		cell_t c;
		int s, pc;
		s  = eff_subdiv();
		pc = eff_patches();
		c  = cell_t'($urandom);
		if (s >= 2 && pc >= 1 && $urandom_range(0, 99) < 85) begin
			c.patch = PATCH_W'($urandom_range(0, pc - 1));
			c.col   = POS_W'($urandom_range(0, s - 1));
			c.row   = POS_W'($urandom_range(0, s - 1 - int'(c.col)));
		end
		return c;
	endfunction

	// reset values: S 17, one patch
	task automatic test_reset_state();
		send_cell(cell_t'{16'd0, 6'd0, 6'd0, MODE_TRI});
		send_cell(cell_t'{16'd1, 6'd0, 6'd0, MODE_ALONG});
		send_cell(cell_t'{16'd0, 6'd16, 6'd0, MODE_PREV_COL});
		send_cell(cell_t'{16'd0, 6'd5, 6'd12, MODE_DIAG});
	endtask

	task automatic test_grid_edges();
		write_reg(REG_SUBDIV, CFG_W'(64));
		write_reg(REG_PATCH_COUNT, CFG_W'(65536));
		send_cell(cell_t'{16'd65535, 6'd63, 6'd0, MODE_PREV_COL});
		send_cell(cell_t'{16'd65535, 6'd63, 6'd0, MODE_DIAG});
		send_cell(cell_t'{16'd65535, 6'd63, 6'd0, MODE_TRI});
		send_cell(cell_t'{16'd65535, 6'd0, 6'd63, MODE_ALONG});
		send_cell(cell_t'{16'd65535, 6'd0, 6'd63, MODE_TRI});
		send_cell(cell_t'{16'd65535, 6'd0, 6'd62, MODE_ALONG});
		send_cell(cell_t'{16'd65535, 6'd10, 6'd20, MODE_TRI});
		send_cell(cell_t'{16'd0, 6'd0, 6'd0, MODE_PREV_COL});
		send_cell(cell_t'{16'd65535, 6'd1, 6'd62, MODE_TRI});
	endtask

	task automatic test_degenerate_sizes();
		write_reg(REG_SUBDIV, CFG_W'(0));
		send_cell(cell_t'{16'd0, 6'd0, 6'd0, MODE_TRI});
		write_reg(REG_SUBDIV, CFG_W'(1));
		send_cell(cell_t'{16'd0, 6'd0, 6'd0, MODE_TRI});
		send_cell(cell_t'{16'd0, 6'd0, 6'd0, MODE_ALONG});
		// 127 saturates to the largest grid
		write_reg(REG_SUBDIV, CFG_W'(127));
		send_cell(cell_t'{16'd300, 6'd63, 6'd0, MODE_PREV_COL});
		// upper bits beyond the register width drop, leaving S = 2
		write_reg(REG_SUBDIV, 17'h1FF82);
		send_cell(cell_t'{16'd0, 6'd1, 6'd0, MODE_TRI});
		send_cell(cell_t'{16'd0, 6'd0, 6'd0, MODE_TRI});
		write_reg(REG_PATCH_COUNT, CFG_W'(0));
		send_cell(cell_t'{16'd0, 6'd1, 6'd0, MODE_PREV_COL});
		write_reg(REG_PATCH_COUNT, CFG_W'(131071));
		send_cell(cell_t'{16'd65535, 6'd1, 6'd0, MODE_PREV_COL});
	endtask

	task automatic test_random_cells();
		int s, pc;
		for (int k = 0; k < 10; k++) begin
			case (k)
				0: begin s = 64;  pc = 65536;  end
				1: begin s = 2;   pc = 3;      end
				2: begin s = 17;  pc = 1;      end
				3: begin s = 64;  pc = 131071; end
				4: begin s = 127; pc = 40;     end
				5: begin s = 40;  pc = 65535;  end
				default: begin
					s  = $urandom_range(2, 64);
					pc = $urandom_range(1, 70000);
				end
			endcase
			write_reg(REG_SUBDIV, CFG_W'(s));
			write_reg(REG_PATCH_COUNT, CFG_W'(pc));
			in_idle  = (k % 3) != 1;
			out_idle = (k % 3) != 2;
			repeat (50) send_cell(random_cell());
		end
	endtask

	// receiver holds off while cells keep coming, so the pipe backs up
	task automatic test_output_stall();
		cell_t c;
		write_reg(REG_SUBDIV, CFG_W'(33));
		write_reg(REG_PATCH_COUNT, CFG_W'(65536));
		in_idle     = 1'b0;
		out_idle    = 1'b0;
		hold_cycles = 150;
		repeat (40) begin
			c      = random_cell();
			c.mode = MODE_TRI;
			send_cell(c);
		end
		in_idle  = 1'b1;
		out_idle = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = REG_SUBDIV;
		cfg_wdata     = '0;
		cell_valid    = 1'b0;
		patch_cell    = '0;
		prim_ready    = 1'b0;
		errors        = 0;
		in_idle       = 1'b1;
		out_idle      = 1'b1;
		hold_cycles   = 0;
		model_subdiv  = S_W'(17);
		model_patches = PC_W'(1);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_grid_edges();
		test_degenerate_sizes();
		test_random_cells();
		test_output_stall();

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_prims.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
